### design/bpr_pkg.sv
// Package for the block pool recycler: operation, status, ownership and
// controller state types, plus default sizing constants.
// No dependencies.
package bpr_pkg;

   // default pool size
   localparam int NUM_BLOCKS_DEF = 16;

   // queue select bit in the shared queue memory address
   localparam logic QSEL_FREE = 1'b0;
   localparam logic QSEL_FILL = 1'b1;

   typedef enum logic [1:0] {
      OP_TAKE_WRITE  = 2'd0,
      OP_COMMIT      = 2'd1,
      OP_TAKE_READ   = 2'd2,
      OP_RELEASE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_OWNED = 2'd2
   } status_type;

   // per-block ownership phase kept in the ownership memory
   typedef enum logic [1:0] {
      OWN_NONE  = 2'd0,
      OWN_WRITE = 2'd1,
      OWN_READ  = 2'd2
   } owner_type;

   typedef enum logic [1:0] {
      S_INIT = 2'd0,
      S_IDLE = 2'd1,
      S_EXEC = 2'd2
   } state_type;

endpackage

### design/block_pool_recycler_top.sv
// Block pool recycler top level: free/filled index queues and ownership
// tracking, kept in two synchronous memories. Depends on bpr_pkg.
//
// Usage: after reset the block runs an initialization pass (busy high)
// that loads the free queue with indices 0..NUM_BLOCKS-1 and clears all
// ownership. A request word is taken when start is high and busy is low;
// busy then stays high for one cycle, so a new word cannot be taken until
// the last one has executed. That gap is set by the registered read of the
// queue or ownership memory followed by the write-back. The response is
// registered from the executing state and appears on rsp_* for exactly
// one cycle with rsp_valid high; it cannot be stalled and is never repeated.
module block_pool_recycler_top
   import bpr_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_op,
   input  logic [IDX_W-1:0] req_block_index,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [IDX_W-1:0] rsp_granted_index
);

   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int QADR_W = IDX_W + 1;
   localparam int QDEPTH = 2 * (1 << IDX_W);

   // memories: both index queues share one, ownership phase in the other
   logic [IDX_W-1:0] queue_mem [QDEPTH];
   owner_type        owner_mem [NUM_BLOCKS];

   // control state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] init_ff, init_in;
   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [IDX_W-1:0] fill_head_ff, fill_head_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // captured request and response payload
   op_type           op_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             in_range_ff;
   status_type       rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_granted_ff, rsp_granted_in;

   // memory ports
   logic [IDX_W-1:0] q_rd_ff;
   owner_type        own_rd_ff;
   logic [QADR_W-1:0] q_rd_addr;
   logic [IDX_W-1:0] own_rd_addr;
   logic             q_we;
   logic [QADR_W-1:0] q_wr_addr;
   logic [IDX_W-1:0] q_wr_data;
   logic             own_we;
   logic [IDX_W-1:0] own_wr_addr;
   owner_type        own_wr_data;

   logic             accept;
   logic             req_in_range;
   logic [SUM_W-1:0] free_sum, fill_sum;
   logic [IDX_W-1:0] free_tail, fill_tail;
   logic [IDX_W-1:0] free_head_nx, fill_head_nx;
   logic             free_full, fill_full;

   assign accept       = start && (state_ff == S_IDLE);
   assign req_in_range = ({1'b0, req_block_index} < QADR_W'(NUM_BLOCKS));

   // tail positions and wrapped head increments
   assign free_sum  = SUM_W'(free_head_ff) + SUM_W'(free_count_ff);
   assign fill_sum  = SUM_W'(fill_head_ff) + SUM_W'(fill_count_ff);
   assign free_tail = (free_sum >= SUM_W'(NUM_BLOCKS)) ?
                      IDX_W'(free_sum - SUM_W'(NUM_BLOCKS)) : IDX_W'(free_sum);
   assign fill_tail = (fill_sum >= SUM_W'(NUM_BLOCKS)) ?
                      IDX_W'(fill_sum - SUM_W'(NUM_BLOCKS)) : IDX_W'(fill_sum);
   assign free_head_nx = (free_head_ff == IDX_W'(NUM_BLOCKS - 1)) ? '0 :
                         free_head_ff + IDX_W'(1);
   assign fill_head_nx = (fill_head_ff == IDX_W'(NUM_BLOCKS - 1)) ? '0 :
                         fill_head_ff + IDX_W'(1);
   assign free_full = (free_count_ff == CNT_W'(NUM_BLOCKS));
   assign fill_full = (fill_count_ff == CNT_W'(NUM_BLOCKS));

   // read addresses, issued with the accepted word
   always_comb begin
      case (op_type'(req_op))
         OP_TAKE_READ: q_rd_addr = {QSEL_FILL, fill_head_ff};
         default:      q_rd_addr = {QSEL_FREE, free_head_ff};
      endcase
      own_rd_addr = req_in_range ? req_block_index : '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: if (init_ff == IDX_W'(NUM_BLOCKS - 1)) state_in = S_IDLE;
         S_IDLE: if (start) state_in = S_EXEC;
         S_EXEC: state_in = S_IDLE;
         default: state_in = S_INIT;
      endcase
   end

   // outputs: init sweep and read-modify-write of the executing word
   always_comb begin
      init_in        = init_ff;
      free_head_in   = free_head_ff;
      free_count_in  = free_count_ff;
      fill_head_in   = fill_head_ff;
      fill_count_in  = fill_count_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_granted_in = '0;
      q_we           = 1'b0;
      q_wr_addr      = {QSEL_FREE, init_ff};
      q_wr_data      = init_ff;
      own_we         = 1'b0;
      own_wr_addr    = init_ff;
      own_wr_data    = OWN_NONE;
      busy           = 1'b1;
      unique case (state_ff)
         S_INIT: begin
            q_we    = 1'b1;
            own_we  = 1'b1;
            init_in = init_ff + IDX_W'(1);
         end
         S_IDLE: begin
            busy = 1'b0;
         end
         S_EXEC: begin
            rsp_valid_in = 1'b1;
            unique case (op_ff)
               OP_TAKE_WRITE: begin
                  if (free_count_ff == '0) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rsp_granted_in = q_rd_ff;
                     own_we         = 1'b1;
                     own_wr_addr    = q_rd_ff;
                     own_wr_data    = OWN_WRITE;
                     free_head_in   = free_head_nx;
                     free_count_in  = free_count_ff - CNT_W'(1);
                  end
               end
               OP_TAKE_READ: begin
                  if (fill_count_ff == '0) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rsp_granted_in = q_rd_ff;
                     own_we         = 1'b1;
                     own_wr_addr    = q_rd_ff;
                     own_wr_data    = OWN_READ;
                     fill_head_in   = fill_head_nx;
                     fill_count_in  = fill_count_ff - CNT_W'(1);
                  end
               end
               OP_COMMIT: begin
                  if (in_range_ff && own_rd_ff == OWN_WRITE) begin
                     own_we      = 1'b1;
                     own_wr_addr = idx_ff;
                     own_wr_data = OWN_NONE;
                     // push dropped on a full queue (cannot occur)
                     if (!fill_full) begin
                        q_we          = 1'b1;
                        q_wr_addr     = {QSEL_FILL, fill_tail};
                        q_wr_data     = idx_ff;
                        fill_count_in = fill_count_ff + CNT_W'(1);
                     end
                  end else begin
                     rsp_status_in = ST_NOT_OWNED;
                  end
               end
               OP_RELEASE: begin
                  if (in_range_ff && own_rd_ff == OWN_READ) begin
                     own_we      = 1'b1;
                     own_wr_addr = idx_ff;
                     own_wr_data = OWN_NONE;
                     if (!free_full) begin
                        q_we          = 1'b1;
                        q_wr_addr     = {QSEL_FREE, free_tail};
                        q_wr_data     = idx_ff;
                        free_count_in = free_count_ff + CNT_W'(1);
                     end
                  end else begin
                     rsp_status_in = ST_NOT_OWNED;
                  end
               end
               default: rsp_status_in = ST_OK;
            endcase
         end
         default: busy = 1'b1;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_ff       <= '0;
         free_head_ff  <= '0;
         free_count_ff <= CNT_W'(NUM_BLOCKS);
         fill_head_ff  <= '0;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         fill_head_ff  <= fill_head_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op_type'(req_op);
         idx_ff      <= req_block_index;
         in_range_ff <= req_in_range;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   // queue memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_wr_addr] <= q_wr_data;
      end
      if (accept) begin
         q_rd_ff <= queue_mem[q_rd_addr];
      end
   end

   // ownership memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (own_we) begin
         owner_mem[own_wr_addr] <= own_wr_data;
      end
      if (accept) begin
         own_rd_ff <= owner_mem[own_rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;

endmodule

### design/bpr_checker.sv
// Port-level checker for the block pool recycler, bound to the top level.
// Depends on bpr_pkg and block_pool_recycler_top.
module bpr_checker
   import bpr_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [1:0]       req_op,
   input logic [IDX_W-1:0] req_block_index,
   input logic             rsp_valid,
   input logic [1:0]       rsp_status,
   input logic [IDX_W-1:0] rsp_granted_index
);

   // a taken word raises busy in the following cycle, holding off the next one
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a word was taken");

   // every response traces back to a taken word, through the executing state and the response register
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without a matching request");

   // a failed operation grants nothing
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_granted_index == '0))
      else $error("index granted on a failed operation");

   // commits and releases never grant an index nor report an empty queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_op, 2) == OP_COMMIT || $past(req_op, 2) == OP_RELEASE))
      |-> (rsp_granted_index == '0 && rsp_status != ST_EMPTY))
      else $error("bad response to commit or release");

   // takes never report a not-owned status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_op, 2) == OP_TAKE_WRITE || $past(req_op, 2) == OP_TAKE_READ))
      |-> (rsp_status != ST_NOT_OWNED))
      else $error("not-owned status on a take");

endmodule

bind block_pool_recycler_top bpr_checker #(.IDX_W(IDX_W)) u_bpr_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_op            (req_op),
   .req_block_index   (req_block_index),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_granted_index (rsp_granted_index)
);

### verif/tb.sv
// Self-checking testbench for block_pool_recycler_top: a table of directed words,
// then random words in three idle phases, checked by table row or pool predictor.
// Depends on bpr_pkg and block_pool_recycler_top.
module tb;
   import bpr_pkg::*;

   localparam int NB = NUM_BLOCKS_DEF;

   typedef struct packed {
      status_type  status;
      logic [3:0]  granted;
   } pool_rsp_type;

   // one directed row; rows with reps > 1 step the index per repetition
   typedef struct packed {
      op_type      op;
      logic [3:0]  idx;
      int          reps;
      bit          known;
      status_type  want_status;
      logic [3:0]  want_granted;
   } dir_row_type;

   localparam int DIR_ROWS = 20;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_op;
   logic [3:0]  req_block_index;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_granted_index;

   // typed expectation travels with the word it belongs to
   bit            hold_known;
   pool_rsp_type  hold_rsp;

   // predictor state: free and filled index rings plus ownership masks
   logic [3:0]  free_ring [NB];
   logic [3:0]  filled_ring [NB];
   int          free_hd, free_cnt, filled_hd, filled_cnt;
   logic [NB-1:0] write_own, read_own;

   pool_rsp_type expected_rsp [$];
   int          errors, words_taken, dir_words;
   int          n_ok, n_empty, n_not_owned;

   dir_row_type dir_tab [DIR_ROWS] = '{
      '{OP_TAKE_READ,  4'd0,  1,  1'b1, ST_EMPTY,     4'd0},
      '{OP_COMMIT,     4'd0,  1,  1'b1, ST_NOT_OWNED, 4'd0},
      '{OP_RELEASE,    4'd15, 1,  1'b1, ST_NOT_OWNED, 4'd0},
      '{OP_TAKE_WRITE, 4'd9,  1,  1'b1, ST_OK,        4'd0},
      '{OP_TAKE_WRITE, 4'd15, 1,  1'b1, ST_OK,        4'd1},
      '{OP_COMMIT,     4'd15, 1,  1'b1, ST_NOT_OWNED, 4'd0},
      '{OP_COMMIT,     4'd1,  1,  1'b1, ST_OK,        4'd0},
      '{OP_COMMIT,     4'd1,  1,  1'b1, ST_NOT_OWNED, 4'd0},
      '{OP_TAKE_READ,  4'd0,  1,  1'b1, ST_OK,        4'd1},
      '{OP_RELEASE,    4'd0,  1,  1'b1, ST_NOT_OWNED, 4'd0},
      '{OP_COMMIT,     4'd0,  1,  1'b1, ST_OK,        4'd0},
      '{OP_RELEASE,    4'd1,  1,  1'b1, ST_OK,        4'd0},
      '{OP_RELEASE,    4'd1,  1,  1'b1, ST_NOT_OWNED, 4'd0},
      '{OP_TAKE_READ,  4'd0,  1,  1'b1, ST_OK,        4'd0},
      '{OP_TAKE_READ,  4'd0,  1,  1'b1, ST_EMPTY,     4'd0},
      // drain the free ring; its tail wrapped when block 1 came back
      '{OP_TAKE_WRITE, 4'd0,  15, 1'b0, ST_OK,        4'd0},
      '{OP_TAKE_WRITE, 4'd0,  1,  1'b1, ST_EMPTY,     4'd0},
      '{OP_COMMIT,     4'd15, 1,  1'b1, ST_OK,        4'd0},
      '{OP_RELEASE,    4'd0,  1,  1'b1, ST_OK,        4'd0},
      '{OP_TAKE_WRITE, 4'd0,  1,  1'b1, ST_OK,        4'd0}
   };

   block_pool_recycler_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // pool state after reset: every block free, in index order
   function automatic void pool_reset();
      for (int i = 0; i < NB; i++) begin
         free_ring[i]   = 4'(i);
         filled_ring[i] = '0;
      end
      free_hd    = 0;
      free_cnt   = NB;
      filled_hd  = 0;
      filled_cnt = 0;
      write_own  = '0;
      read_own   = '0;
   endfunction

   // apply one word to the pool and return the response it produces
   function automatic pool_rsp_type pool_step(op_type op, logic [3:0] idx);
      pool_rsp_type r;
      r.status  = ST_OK;
      r.granted = '0;
      case (op)
         OP_TAKE_WRITE: begin
            if (free_cnt == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.granted = free_ring[free_hd];
               write_own[r.granted] = 1'b1;
               free_hd = (free_hd + 1) % NB;
               free_cnt--;
            end
         end
         OP_COMMIT: begin
            if (int'(idx) < NB && write_own[idx]) begin
               write_own[idx] = 1'b0;
               if (filled_cnt < NB) begin
                  filled_ring[(filled_hd + filled_cnt) % NB] = idx;
                  filled_cnt++;
               end
            end else begin
               r.status = ST_NOT_OWNED;
            end
         end
         OP_TAKE_READ: begin
            if (filled_cnt == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.granted = filled_ring[filled_hd];
               read_own[r.granted] = 1'b1;
               filled_hd = (filled_hd + 1) % NB;
               filled_cnt--;
            end
         end
         default: begin
            if (int'(idx) < NB && read_own[idx]) begin
               read_own[idx] = 1'b0;
               if (free_cnt < NB) begin
                  free_ring[(free_hd + free_cnt) % NB] = idx;
                  free_cnt++;
               end
            end else begin
               r.status = ST_NOT_OWNED;
            end
         end
      endcase
      return r;
   endfunction

   // random member of an ownership mask (mask must be nonzero)
   function automatic logic [3:0] pick_owned(logic [NB-1:0] mask);
      int s;
      s = $urandom_range(NB - 1);
      for (int i = 0; i < NB; i++) begin
         if (mask[(s + i) % NB]) return 4'((s + i) % NB);
      end
      return '0;
   endfunction

   // check responses, then predict for a word taken at this edge
   always @(posedge clock) begin
      pool_rsp_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            case (rsp_status)
               ST_OK:        n_ok++;
               ST_EMPTY:     n_empty++;
               ST_NOT_OWNED: n_not_owned++;
               default:      ;
            endcase
            if (expected_rsp.size() == 0) begin
               errors++;
               $error("response with none pending: status %0d granted %0d",
                      rsp_status, rsp_granted_index);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_status !== want.status) begin
                  errors++;
                  $error("status: expected %0d actual %0d", want.status, rsp_status);
               end
               if (rsp_granted_index !== want.granted) begin
                  errors++;
                  $error("granted_index: expected %0d actual %0d",
                         want.granted, rsp_granted_index);
               end
            end
         end else if (rsp_valid !== 1'b0) begin
            errors++;
            $error("rsp_valid: expected 0 or 1 actual %b", rsp_valid);
         end
         if (start && busy === 1'b0) begin
            want = pool_step(op_type'(req_op), req_block_index);
            if (hold_known) want = hold_rsp;
            expected_rsp.push_back(want);
            words_taken++;
         end
      end
   end

   // drive start low and junk on the request fields up to the next clock edge
   task automatic idle_cycle();
      start           <= 1'b0;
      req_op          <= 2'($urandom);
      req_block_index <= 4'($urandom);
      @(posedge clock);
   endtask

   // hold a word until it is taken, then idle with the given odds per cycle
   task automatic send_word(op_type op, logic [3:0] idx, bit known, pool_rsp_type rsp,
                            int idle_pct);
      start           <= 1'b1;
      req_op          <= op;
      req_block_index <= idx;
      hold_known      <= known;
      hold_rsp        <= rsp;
      do @(posedge clock); while (busy !== 1'b0);
      while ($urandom_range(99) < idle_pct) idle_cycle();
   endtask

   initial begin
      pool_rsp_type fixed_rsp;
      op_type      op;
      logic [3:0]  idx;
      int          idle_pct;
      int          drain;

      reset           = 1'b1;
      start           = 1'b0;
      req_op          = '0;
      req_block_index = '0;
      hold_known      = 1'b0;
      hold_rsp        = '0;
      errors          = 0;
      words_taken     = 0;
      n_ok            = 0;
      n_empty         = 0;
      n_not_owned     = 0;
      pool_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_tab[i]) begin
         fixed_rsp.status  = dir_tab[i].want_status;
         fixed_rsp.granted = dir_tab[i].want_granted;
         for (int r = 0; r < dir_tab[i].reps; r++) begin
            send_word(dir_tab[i].op, dir_tab[i].idx + 4'(r), dir_tab[i].known,
                      fixed_rsp, 0);
         end
      end
      dir_words = words_taken;

      // random words: all four ops alike; commits/releases mostly of owned blocks, some strays
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 20 : (phase == 1) ? 71 : 0;
         repeat (150) begin
            op  = op_type'($urandom_range(3));
            idx = 4'($urandom_range(NB - 1));
            if (op == OP_COMMIT && write_own != '0 && $urandom_range(99) < 85)
               idx = pick_owned(write_own);
            if (op == OP_RELEASE && read_own != '0 && $urandom_range(99) < 85)
               idx = pick_owned(read_own);
            send_word(op, idx, 1'b0, '0, idle_pct);
         end
      end
      start <= 1'b0;

      // let the last responses come back
      drain = 0;
      while (expected_rsp.size() != 0 && drain < 100) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         errors++;
         $error("%0d responses never arrived", expected_rsp.size());
      end

      $display("Sent %0d words (%0d directed) across three idle mixes;", words_taken,
               dir_words);
      $display("responses seen: %0d ok, %0d queue empty, %0d not owned", n_ok, n_empty,
               n_not_owned);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
